// ----- rtl/core/bperim_pkg.sv -----
// Shared types and constants of the binary perimeter marker.
package bperim_pkg;

  // Widths fixed by the register map and the result format.
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned OUT_COORD_W = 10;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned DIM_RESET   = 1024;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Class flags of one pixel.
  typedef struct packed {
    logic pos;
    logic zero;
  } flags_t;

  // One line buffer entry: flags of the rows two above and one above.
  typedef struct packed {
    flags_t up;
    flags_t mid;
  } line_t;

  // One window column: flags of the rows two above, one above and current.
  typedef struct packed {
    flags_t up;
    flags_t mid;
    flags_t cur;
  } col_t;

endpackage

// ----- rtl/core/bperim_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bperim_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/binary_perimeter_3x3_top.sv -----
// Top level of the binary perimeter marker with a 3x3 window.
//
// Takes one signed pixel per cycle in raster order unless the output stalls
// and, for every interior pixel, gives its row, column and a flag set when the
// pixel is positive and one of its eight neighbours is exactly zero; border
// pixels give no result. A result passes the stage one and result registers
// once the pixel below-right of the judged pixel is taken. The pixel rate is
// set by the line buffer RAM: its entry is read when a pixel is taken and
// written back when it leaves stage one, with a bypass register covering a
// read of the column being written. The line buffers start undefined, so the
// first two rows after reset must be delivered before any verdict is relied
// on; the frame counters advance across frames without a gap. The user must
// write width and height only while the block is idle; the block does not
// check this. A zero acts as one and a value above the maximum as the maximum.
module binary_perimeter_3x3_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [bperim_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [bperim_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Pixel stream. tdata: pixel_value.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // Result stream. tdata: out_row, out_col, is_perimeter, zero fill.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata
);
  import bperim_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned HW = (RW > CFG_W) ? RW : CFG_W;
  localparam int unsigned W_RST = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
  localparam int unsigned H_RST = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

  // Configuration registers, held already clamped.
  logic [CW-1:0] width_q;
  logic [RW-1:0] height_q;
  logic [WW-1:0] width_ext;
  logic [HW-1:0] height_ext;
  logic [CW-1:0] width_clamp;
  logic [RW-1:0] height_clamp;

  // Frame position of the next pixel.
  logic [CW-1:0] col_q, col_d, c_in, c_nxt;
  logic [RW-1:0] row_q, row_d, r_in, r_tmp, r_nxt;
  logic          col_wrap, end_row;

  // Stage one: the pixel being judged against the line buffer.
  logic                   s1_valid_q;
  flags_t                 s1_flags_q;
  logic [AW-1:0]          s1_addr_q;
  logic                   s1_res_q;
  logic [OUT_COORD_W-1:0] s1_row_q, s1_col_q;
  flags_t                 flags_in;
  logic [PIXEL_BITS-1:0]  pixel;

  // Line buffer and write-to-read bypass.
  line_t  ram_rdata, line_rd, line_wr, byp_q;
  logic   byp_sel_q, byp_sel_d;

  // Window and result register.
  col_t [2:0]             win_q, win_d;
  col_t                   column;
  logic                   any_zero, verdict;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_COORD_W-1:0] out_row_q, out_col_q;
  logic                   out_perim_q;

  // Handshake.
  logic accept, s1_adv, out_free, out_load;

  // Clamp a written dimension into one to the maximum.
  always_comb begin
    width_ext  = WW'(cfg_wdata_i);
    height_ext = HW'(cfg_wdata_i);
    if (cfg_wdata_i == '0) begin
      width_clamp = CW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_clamp = CW'(MAX_WIDTH);
    end else begin
      width_clamp = width_ext[CW-1:0];
    end
    if (cfg_wdata_i == '0) begin
      height_clamp = RW'(1);
    end else if (height_ext > HW'(MAX_HEIGHT)) begin
      height_clamp = RW'(MAX_HEIGHT);
    end else begin
      height_clamp = height_ext[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(W_RST);
      height_q <= RW'(H_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_IMAGE_WIDTH:  width_q  <= width_clamp;
        CFG_IMAGE_HEIGHT: height_q <= height_clamp;
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    col_wrap = col_q >= width_q;
    c_in     = col_wrap ? '0 : col_q;
    r_tmp    = col_wrap ? RW'(row_q + 1'b1) : row_q;
    r_in     = (r_tmp >= height_q) ? '0 : r_tmp;
    c_nxt    = CW'(c_in + 1'b1);
    end_row  = c_nxt >= width_q;
    r_nxt    = end_row ? RW'(r_in + 1'b1) : r_in;
    col_d    = end_row ? '0 : c_nxt;
    row_d    = (r_nxt >= height_q) ? '0 : r_nxt;
  end

  // Pixel classification.
  always_comb begin
    pixel         = s_axis_tdata[PIXEL_BITS-1:0];
    flags_in.zero = pixel == '0;
    flags_in.pos  = (pixel != '0) && !pixel[PIXEL_BITS-1];
  end

  // Flow control: stage one moves on unless its result finds the output full.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_res_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = s1_adv && s1_res_q;

  // A read of the column written in the same cycle takes the new entry.
  assign byp_sel_d = s1_adv && (s1_addr_q == c_in[AW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_sel_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        byp_sel_q <= byp_sel_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage one payload, with the result coordinates worked out ahead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= flags_in;
      s1_addr_q  <= c_in[AW-1:0];
      s1_res_q   <= (r_in >= RW'(2)) && (c_in >= CW'(2));
      s1_row_q   <= OUT_COORD_W'(32'(r_in) - 32'd1);
      s1_col_q   <= OUT_COORD_W'(32'(c_in) - 32'd1);
      byp_q      <= line_wr;
    end
  end

  // Both line buffers share one RAM entry per column.
  bperim_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (accept),
    .raddr_i (c_in[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // New window column and the entry written back.
  always_comb begin
    line_rd     = byp_sel_q ? byp_q : ram_rdata;
    column.up   = line_rd.up;
    column.mid  = line_rd.mid;
    column.cur  = s1_flags_q;
    line_wr.up  = line_rd.mid;
    line_wr.mid = s1_flags_q;
  end

  // Shift the window and judge its centre.
  always_comb begin
    win_d    = {win_q[1:0], column};
    any_zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      any_zero = any_zero | win_d[i].up.zero | win_d[i].mid.zero | win_d[i].cur.zero;
    end
    verdict = win_d[1].mid.pos & any_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // Result register.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q   <= s1_row_q;
      out_col_q   <= s1_col_q;
      out_perim_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_perim_q, out_col_q, out_row_q};

  // A result handed on by stage one is held for the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result from stage one was not registered");

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("pending result overwritten");

  // A taken pixel is always in stage one on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost before stage one");

endmodule
